[rtl/ico_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ico_pkg: shared definitions for intensity_centroid_orientation
// Field widths, register codes, rotation constants and the arctangent table.
// ----------------------------------------------------------------------------
package ico_pkg;

	// default largest patch side
	localparam int MAX_DIM_DEF = 64;

	// field widths
	localparam int PIXEL_W   = 8;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 8;
	localparam int ANGLE_W   = 15;

	// register reset values
	localparam logic [CFG_W-1:0] PATCH_ROWS_RST = 7'd31;
	localparam logic [CFG_W-1:0] PATCH_COLS_RST = 7'd31;

	// register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATCH_ROWS = 8'd0,
		REG_PATCH_COLS = 8'd1
	} cfg_reg_t;

	// rotation unit constants
	localparam int PRE_SHIFT    = 20;
	localparam int CORDIC_STEPS = 21;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int Z_W          = 24;
	localparam int ANGLE_MAX    = 5760;
	localparam int ROUND_BITS   = 10;

	// output queue depth between accumulator and rotation unit
	localparam int Q_DEPTH = 4;

	// rotation unit sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} rot_state_t;

	// atan(2^-i) in degrees times 65536, rounded
	function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			5'd0:    v = 24'sd2949120;
			5'd1:    v = 24'sd1740967;
			5'd2:    v = 24'sd919879;
			5'd3:    v = 24'sd466945;
			5'd4:    v = 24'sd234379;
			5'd5:    v = 24'sd117304;
			5'd6:    v = 24'sd58666;
			5'd7:    v = 24'sd29335;
			5'd8:    v = 24'sd14668;
			5'd9:    v = 24'sd7334;
			5'd10:   v = 24'sd3667;
			5'd11:   v = 24'sd1833;
			5'd12:   v = 24'sd917;
			5'd13:   v = 24'sd458;
			5'd14:   v = 24'sd229;
			5'd15:   v = 24'sd115;
			5'd16:   v = 24'sd57;
			5'd17:   v = 24'sd29;
			5'd18:   v = 24'sd14;
			5'd19:   v = 24'sd7;
			5'd20:   v = 24'sd4;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/ico_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ico_accum: pixel front end
// Holds the size registers, counts row and column, accumulates the column
// and row moments and pushes both moments when the last pixel of a patch
// is taken.
// ----------------------------------------------------------------------------
module ico_accum #(
	parameter int MAX_DIM = ico_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [ico_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ico_pkg::CFG_W-1:0]     cfg_data,
	// pixel stream
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  logic [ico_pkg::PIXEL_W-1:0]   pix,
	// moment push toward the queue
	output logic                          push,
	input  logic                          q_full,
	output logic [3*$clog2(MAX_DIM)+8-1:0] col_mom,
	output logic [3*$clog2(MAX_DIM)+8-1:0] row_mom
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int MOM_W = 3 * IDX_W + 8;
	localparam int XW    = ico_pkg::CFG_W + $clog2(MAX_DIM + 1);
	localparam int PR_W  = IDX_W + ico_pkg::PIXEL_W;

	logic [ico_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [IDX_W-1:0]          row_q, col_q;
	logic [MOM_W-1:0]          col_sum_q, row_sum_q;
	logic [XW-1:0]             rows_eff, cols_eff;
	logic [XW-1:0]             col_nxt, row_nxt;
	logic [PR_W-1:0]           col_prod, row_prod;
	logic [MOM_W-1:0]          col_sum_nxt, row_sum_nxt;
	logic                      take, row_end, patch_end;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= ico_pkg::PATCH_ROWS_RST;
			cols_cfg_q <= ico_pkg::PATCH_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ico_pkg::REG_PATCH_ROWS: rows_cfg_q <= cfg_data;
				ico_pkg::REG_PATCH_COLS: cols_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes: zero acts as one, clamp to MAX_DIM
	always_comb begin
		rows_eff = XW'(rows_cfg_q);
		cols_eff = XW'(cols_cfg_q);
		if (rows_cfg_q == '0)
			rows_eff = XW'(1);
		else if (rows_eff > XW'(MAX_DIM))
			rows_eff = XW'(MAX_DIM);
		if (cols_cfg_q == '0)
			cols_eff = XW'(1);
		else if (cols_eff > XW'(MAX_DIM))
			cols_eff = XW'(MAX_DIM);
	end

	// position and moment update
	assign pix_ready   = !q_full;
	assign take        = pix_valid && pix_ready;
	assign col_nxt     = XW'(col_q) + XW'(1);
	assign row_nxt     = XW'(row_q) + XW'(1);
	assign row_end     = !(col_nxt < cols_eff);
	assign patch_end   = row_end && !(row_nxt < rows_eff);
	assign col_prod    = col_q * pix;
	assign row_prod    = row_q * pix;
	assign col_sum_nxt = col_sum_q + MOM_W'(col_prod);
	assign row_sum_nxt = row_sum_q + MOM_W'(row_prod);

	assign push    = take && patch_end;
	assign col_mom = col_sum_nxt;
	assign row_mom = row_sum_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (take) begin
			if (!row_end) begin
				col_q     <= IDX_W'(col_nxt);
				col_sum_q <= col_sum_nxt;
				row_sum_q <= row_sum_nxt;
			end else if (!patch_end) begin
				col_q     <= '0;
				row_q     <= IDX_W'(row_nxt);
				col_sum_q <= col_sum_nxt;
				row_sum_q <= row_sum_nxt;
			end else begin
				col_q     <= '0;
				row_q     <= '0;
				col_sum_q <= '0;
				row_sum_q <= '0;
			end
		end
	end

endmodule

[rtl/ico_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ico_fifo: moment queue
// Short first-in first-out buffer of moment pairs between the pixel front
// end and the rotation unit.
// ----------------------------------------------------------------------------
module ico_fifo #(
	parameter int W     = 52,
	parameter int DEPTH = ico_pkg::Q_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

[rtl/ico_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ico_cordic: orientation back end
// Takes one moment pair from the queue, runs the vectoring rotation one
// step per cycle, rounds the angle and holds it in the output register.
// ----------------------------------------------------------------------------
module ico_cordic #(
	parameter int MAX_DIM = ico_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// moment pair from the queue
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [3*$clog2(MAX_DIM)+8-1:0] col_mom,
	input  logic [3*$clog2(MAX_DIM)+8-1:0] row_mom,
	// result
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [ico_pkg::ANGLE_W-1:0]   res_angle,
	output logic                          res_empty
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int MOM_W = 3 * IDX_W + 8;
	localparam int CW    = MOM_W + ico_pkg::PRE_SHIFT + 3;
	localparam int Z_W   = ico_pkg::Z_W;

	ico_pkg::rot_state_t state_q, state_nxt;

	logic signed [CW-1:0]              x_q, y_q, dx, dy;
	logic signed [Z_W-1:0]             z_q, z_rnd;
	logic [ico_pkg::STEP_W-1:0]        step_q;
	logic                              empty_q;
	logic                              out_valid_q, out_empty_q;
	logic [ico_pkg::ANGLE_W-1:0]       out_angle_q, angle_fin;
	logic                              load, iterate, finish;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ico_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// sequencer
	always_comb begin
		state_nxt = state_q;
		load      = 1'b0;
		iterate   = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ico_pkg::ST_IDLE: begin
				if (q_valid) begin
					load      = 1'b1;
					state_nxt = ico_pkg::ST_RUN;
				end
			end
			ico_pkg::ST_RUN: begin
				iterate = 1'b1;
				if (step_q == ico_pkg::STEP_W'(ico_pkg::CORDIC_STEPS - 1))
					state_nxt = ico_pkg::ST_DONE;
			end
			ico_pkg::ST_DONE: begin
				if (!out_valid_q || res_ready) begin
					finish    = 1'b1;
					state_nxt = ico_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ico_pkg::ST_IDLE;
		endcase
	end

	assign q_pop = load;

	// one rotation step; shifts floor toward minus infinity
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	always_ff @(posedge clk) begin
		if (load) begin
			x_q     <= $signed({3'b000, row_mom, {ico_pkg::PRE_SHIFT{1'b0}}});
			y_q     <= $signed({3'b000, col_mom, {ico_pkg::PRE_SHIFT{1'b0}}});
			z_q     <= '0;
			step_q  <= '0;
			empty_q <= (col_mom == '0) && (row_mom == '0);
		end else if (iterate) begin
			step_q <= step_q + ico_pkg::STEP_W'(1);
			if (y_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ico_pkg::atan_lut(step_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ico_pkg::atan_lut(step_q);
			end
		end
	end

	// round to 1/64 degree, clamp at 90 degrees
	assign z_rnd = z_q + Z_W'(512);
	always_comb begin
		angle_fin = '0;
		if (!empty_q && !z_q[Z_W-1]) begin
			if ((z_rnd >>> ico_pkg::ROUND_BITS) > Z_W'(ico_pkg::ANGLE_MAX))
				angle_fin = ico_pkg::ANGLE_W'(ico_pkg::ANGLE_MAX);
			else
				angle_fin = ico_pkg::ANGLE_W'(z_rnd >>> ico_pkg::ROUND_BITS);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_angle_q <= angle_fin;
			out_empty_q <= empty_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res_angle = out_angle_q;
	assign res_empty = out_empty_q;

endmodule

[rtl/intensity_centroid_orientation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intensity_centroid_orientation: patch orientation by intensity centroid
// Streams gray pixels of square or rectangular patches in raster order and
// returns atan2(column moment, row moment) per patch in 1/64 degree units.
// ----------------------------------------------------------------------------
// Usage:
//  - s_tdata carries one 8-bit pixel per transfer, raster order. One pixel is
//    taken per cycle while the moment queue has room.
//  - cfg_* writes patch_rows (index 0) and patch_cols (index 1); cfg_ready is
//    always high. Write only while the block is idle.
//  - m_tdata carries the angle (0..5760) and m_tuser the empty-patch flag, one
//    transfer per patch, after the last pixel of that patch.
//  - Result path: with the rotation unit idle, the last pixel's moments are
//    queued, loaded, rotated and rounded into the output register.
//  - Throughput: pixels at one per cycle while the queue has room; the rotation
//    unit takes one patch at a time (load, 21 steps, round), so patches arriving
//    faster than it ends them fill the 4-entry moment queue, then s_tready drops.
//  - Stall: a held m_tvalid keeps the rotation unit waiting in its final
//    state; the queue keeps filling until full, then pixels back-pressure.
//  - Reset: counters, sums, queue and output clear; sizes return to 31 x 31.
// ----------------------------------------------------------------------------
module intensity_centroid_orientation #(
	parameter int MAX_DIM = ico_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [14:0] angle, [15] zero
	output logic                          m_tuser,   // [0] empty_patch
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ico_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ico_pkg::CFG_W-1:0]     cfg_data
);

	localparam int MOM_W = 3 * $clog2(MAX_DIM) + 8;

	logic                          push, q_full, q_valid, q_pop;
	logic [MOM_W-1:0]              col_mom, row_mom, q_col, q_row;
	logic [ico_pkg::ANGLE_W-1:0]   angle;

	assign cfg_ready = 1'b1;

	// front end: counters and moments
	ico_accum #(
		.MAX_DIM(MAX_DIM)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (s_tvalid),
		.pix_ready (s_tready),
		.pix       (s_tdata),
		.push      (push),
		.q_full    (q_full),
		.col_mom   (col_mom),
		.row_mom   (row_mom)
	);

	// moment queue
	ico_fifo #(
		.W     (2 * MOM_W),
		.DEPTH (ico_pkg::Q_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({col_mom, row_mom}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  ({q_col, q_row})
	);

	// back end: rotation and rounding
	ico_cordic #(
		.MAX_DIM(MAX_DIM)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.col_mom   (q_col),
		.row_mom   (q_row),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_angle (angle),
		.res_empty (m_tuser)
	);

	assign m_tdata = {1'b0, angle};

endmodule

[tb/ico_orientation_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ico_orientation_checker: scoreboard for intensity_centroid_orientation
// Watches the pixel, result and register channels, keeps its own patch
// counters and moments, predicts each patch angle with a bit-exact rotation
// and compares every result transfer against the oldest open prediction.
// ----------------------------------------------------------------------------
module ico_orientation_checker #(
	parameter int MAX_SIDE = ico_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel stream
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,    // [7:0] pixel
	// result stream
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [15:0]                   m_tdata,    // [14:0] angle, [15] zero
	input  logic                          m_tuser,    // [0] empty_patch
	// register writes
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ico_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ico_pkg::CFG_W-1:0]     cfg_data,
	// status for the stimulus side
	output int                            pending,
	output int                            mismatches,
	output int                            patches_seen,
	output int                            empty_seen
);

	// rotation constants, angle in 1/65536 degree before rounding
	localparam int ROT_STEPS    = 21;
	localparam int ROT_PRESHIFT = 20;
	localparam int ROUND_SHIFT  = 10;
	localparam int ANGLE_CAP    = 5760;
	localparam int ANG_W        = ico_pkg::ANGLE_W;

	typedef struct packed {
		logic [ANG_W-1:0] angle;
		logic             empty_patch;
	} orient_t;

	// atan(2^-i) in degrees times 65536
	longint atan_deg16 [ROT_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4
	};

	logic [ico_pkg::CFG_W-1:0] rows_reg;
	logic [ico_pkg::CFG_W-1:0] cols_reg;
	int                        row_pos;
	int                        col_pos;
	longint                    col_moment;
	longint                    row_moment;
	orient_t                   orient_q[$];
	int                        err_cnt;
	int                        res_cnt;
	int                        empty_cnt;

	// register value to patch side: zero acts as one, large values clamp
	function automatic int side_of(input logic [ico_pkg::CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return int'(v);
	endfunction

	// vectoring rotation of (row moment, column moment) toward the x axis
	function automatic logic [ANG_W-1:0] centroid_angle(input longint col_m,
	                                                    input longint row_m);
		longint x, y, z, dx, dy, k;
		x = row_m <<< ROT_PRESHIFT;
		y = col_m <<< ROT_PRESHIFT;
		z = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + atan_deg16[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - atan_deg16[i];
			end
		end
		if (z < 0) return '0;
		k = (z + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		if (k > ANGLE_CAP) k = ANGLE_CAP;
		return ANG_W'(k);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] checker: %s", $time, what);
		err_cnt++;
	endtask

	// accumulate one pixel; close the patch after its last pixel
	task automatic take_pixel(input logic [ico_pkg::PIXEL_W-1:0] p);
		orient_t res;
		col_moment = col_moment + col_pos * int'(p);
		row_moment = row_moment + row_pos * int'(p);
		if (col_pos + 1 < side_of(cols_reg)) begin
			col_pos++;
		end else begin
			col_pos = 0;
			if (row_pos + 1 < side_of(rows_reg)) begin
				row_pos++;
			end else begin
				res.empty_patch = (col_moment == 0 && row_moment == 0);
				res.angle = res.empty_patch ? '0 : centroid_angle(col_moment, row_moment);
				orient_q   = {orient_q, res};
				row_pos    = 0;
				col_moment = 0;
				row_moment = 0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		orient_t want;
		if (!arst_n) begin
			rows_reg   = ico_pkg::PATCH_ROWS_RST;
			cols_reg   = ico_pkg::PATCH_COLS_RST;
			row_pos    = 0;
			col_pos    = 0;
			col_moment = 0;
			row_moment = 0;
			orient_q.delete();
			pending    <= 0;
		end else begin
			// result transfer against the oldest open patch
			if (m_tvalid && m_tready) begin
				res_cnt++;
				if (m_tuser) empty_cnt++;
				if (orient_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no patch closed",
						res_cnt));
				end else begin
					want = orient_q.pop_front();
					if (m_tdata[ANG_W-1:0] !== want.angle)
						report_mismatch($sformatf("patch %0d angle %0d, predicted %0d",
							res_cnt, m_tdata[ANG_W-1:0], want.angle));
					if (m_tdata[15:ANG_W] !== '0)
						report_mismatch($sformatf("patch %0d pad bit of tdata is %b",
							res_cnt, m_tdata[15:ANG_W]));
					if (m_tuser !== want.empty_patch)
						report_mismatch($sformatf("patch %0d empty flag %b, predicted %b",
							res_cnt, m_tuser, want.empty_patch));
				end
			end
			// pixel transfer, sized by the registers held before this edge
			if (s_tvalid && s_tready) take_pixel(s_tdata);
			// register transfer, seen by the pixels after this edge
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ico_pkg::REG_PATCH_ROWS: rows_reg = cfg_data;
					ico_pkg::REG_PATCH_COLS: cols_reg = cfg_data;
					default: ;
				endcase
			end
			pending <= orient_q.size();
		end
		mismatches   <= err_cnt;
		patches_seen <= res_cnt;
		empty_seen   <= empty_cnt;
	end

endmodule

[tb/tb_intensity_centroid_orientation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intensity_centroid_orientation: stimulus and verdict
// Streams pixel patches of many sizes through the block, including zero and
// oversized register values and size changes in the middle of a patch, with
// random gaps on the pixel side and random stalls on the result side. A
// separate checker predicts and compares every angle.
// ----------------------------------------------------------------------------
module tb_intensity_centroid_orientation;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int PHASE_PIXELS  = 300;
	localparam int PIX_W         = ico_pkg::PIXEL_W;
	localparam int REG_W         = ico_pkg::CFG_W;
	localparam int SIDE_MAX      = ico_pkg::MAX_DIM_DEF;
	localparam int RESET_SIDE    = 31;

	// index with no register behind it, every bit set
	localparam logic [ico_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;
	localparam logic [PIX_W-1:0]              PIX_BLACK    = 8'h00;
	localparam logic [PIX_W-1:0]              PIX_WHITE    = 8'hFF;

	typedef enum int {
		TEX_NOISE,
		TEX_SPARSE,
		TEX_BLACK,
		TEX_WHITE,
		TEX_BINARY
	} texture_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [7:0]                    s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [15:0]                   m_tdata;
	logic                          m_tuser;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ico_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]              cfg_data;

	int pending;
	int mismatches;
	int patches_seen;
	int empty_seen;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_asked;
	int hold_served = 0;
	int pixels_sent;
	int stall_cycles = 0;

	always #(CLK_HALF) clk = ~clk;

	intensity_centroid_orientation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ico_orientation_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.mismatches   (mismatches),
		.patches_seen (patches_seen),
		.empty_seen   (empty_seen)
	);

	// cycles in which a pixel waits on back-pressure
	always @(posedge clk) begin
		if (arst_n && s_tvalid && !s_tready) stall_cycles++;
	end

	// result side: random stalls, plus one long hold when asked
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic int side_len(input int v);
		return (v == 0) ? 1 : (v > SIDE_MAX) ? SIDE_MAX : v;
	endfunction

	function automatic int pick_side();
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 75) return $urandom_range(1, 6);
		return $urandom_range(7, 16);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(input texture_t tex);
		case (tex)
			TEX_SPARSE: return ($urandom_range(9) == 0) ? PIX_W'($urandom_range(255))
			                                            : PIX_BLACK;
			TEX_BLACK:  return PIX_BLACK;
			TEX_WHITE:  return PIX_WHITE;
			TEX_BINARY: return $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
			default:    return PIX_W'($urandom_range(255));
		endcase
	endfunction

	// one pixel transfer, with random gaps before it
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	task automatic send_patch(input int count, input texture_t tex);
		for (int i = 0; i < count; i++) send_pixel(pick_pixel(tex));
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [ico_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// stop pixels until every open patch has reported, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input int rows, input int cols);
		settle();
		write_reg(ico_pkg::REG_PATCH_ROWS, REG_W'(rows));
		write_reg(ico_pkg::REG_PATCH_COLS, REG_W'(cols));
		cfg_valid <= 1'b0;
	endtask

	// random sizes and textures until the pixel budget is spent
	task automatic run_phase(input int snd_idle, input int rcv_idle, input int budget);
		int start, rows, cols, area, npatch, k, r;
		texture_t tex;
		send_idle_pct = snd_idle;
		recv_idle_pct = rcv_idle;
		start = pixels_sent;
		while (pixels_sent - start < budget) begin
			rows = pick_side();
			cols = pick_side();
			// now and then one side at or beyond the largest size
			if ($urandom_range(11) == 0) begin
				rows = $urandom_range(SIDE_MAX, 127);
				cols = $urandom_range(1, 4);
				if ($urandom_range(1)) begin
					k    = rows;
					rows = cols;
					cols = k;
				end
			end
			set_size(rows, cols);
			area   = side_len(rows) * side_len(cols);
			npatch = $urandom_range(1, 5);
			for (k = 0; k < npatch && pixels_sent - start < budget; k++) begin
				r   = $urandom_range(99);
				tex = (r < 40) ? TEX_NOISE : (r < 65) ? TEX_SPARSE :
				      (r < 80) ? TEX_BLACK : TEX_BINARY;
				send_patch(area, tex);
			end
			// leave a patch unfinished so the next size change lands mid-patch
			if (area > 1 && $urandom_range(3) == 0)
				send_patch($urandom_range(1, area - 1), TEX_NOISE);
		end
	endtask

	// stimulus
	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = ico_pkg::REG_PATCH_ROWS;
		cfg_data      = '0;
		send_idle_pct = 28;
		recv_idle_pct = 82;
		hold_asked    = 0;
		pixels_sent   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one full row at the sizes left by reset, then one pixel per row
		// down to the last reset row, which closes the patch
		send_patch(RESET_SIDE, TEX_NOISE);
		settle();
		write_reg(ico_pkg::REG_PATCH_COLS, 7'd1);
		cfg_valid <= 1'b0;
		send_patch(RESET_SIDE - 1, TEX_NOISE);

		// single pixel patches: dark, and bright at the origin, both empty
		set_size(1, 1);
		send_pixel(PIX_BLACK);
		send_pixel(PIX_WHITE);

		// zero sizes act as one; a write to an unmapped index changes nothing
		settle();
		write_reg(REG_UNMAPPED, 7'h7F);
		write_reg(ico_pkg::REG_PATCH_ROWS, 7'd0);
		write_reg(ico_pkg::REG_PATCH_COLS, 7'd0);
		cfg_valid <= 1'b0;
		send_pixel(8'hA5);

		// mass right of the origin points at 90 degrees; mass at the origin is empty
		set_size(1, 2);
		send_pixel(PIX_BLACK);
		send_pixel(PIX_WHITE);
		send_pixel(PIX_WHITE);
		send_pixel(PIX_BLACK);

		// mass below the origin gives angle zero without the empty flag
		set_size(2, 1);
		send_pixel(PIX_BLACK);
		send_pixel(PIX_WHITE);

		// diagonal mass and alternating bit patterns
		set_size(2, 2);
		send_pixel(8'h00);
		send_pixel(8'h01);
		send_pixel(8'h01);
		send_pixel(8'h00);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		send_pixel(8'hAA);
		send_pixel(8'h55);

		// shrink the row length in the middle of a patch: the next pixel closes it
		send_pixel(8'h09);
		send_pixel(8'hC8);
		send_pixel(8'h11);
		set_size(2, 1);
		send_pixel(8'h3C);

		// random phases with changing gap patterns
		run_phase(28, 82, PHASE_PIXELS);
		run_phase(82, 28, PHASE_PIXELS);
		run_phase(0, 0, PHASE_PIXELS);

		// short patches while results are held back, so the queue fills and pixels stall
		set_size(2, 2);
		hold_asked++;
		send_patch(120, TEX_NOISE);

		// tallest and widest patches, full white, long side clamped from oversized values
		set_size(127, 2);
		send_patch(SIDE_MAX * 2, TEX_WHITE);
		set_size(2, 100);
		send_patch(2 * SIDE_MAX, TEX_WHITE);
		settle();

		$display("Covered %0d pixels in %0d patches (%0d empty), sides from 1 to 64 incl. zero",
			pixels_sent, patches_seen, empty_seen);
		$display("and oversized settings, mid-patch size changes, %0d cycles of pixel stall.",
			stall_cycles);
		if (mismatches == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("Run exceeded its time limit, %0d patches still open", pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
rtl/ico_pkg.sv
rtl/ico_accum.sv
rtl/ico_fifo.sv
rtl/ico_cordic.sv
rtl/intensity_centroid_orientation.sv
tb/ico_orientation_checker.sv
tb/tb_intensity_centroid_orientation.sv
